// ===== hdl/ircfs_pkg.sv =====
// Package for the chat message field splitter.
// Holds the phase, field class and error codes and the result word type.
// No dependencies.
`default_nettype none

package ircfs_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned ClassW = 3;
  localparam int unsigned ErrW   = 3;
  localparam int unsigned PhaseW = 4;

  // Parse phases.
  localparam logic [PhaseW-1:0] PH_START      = 4'd0;
  localparam logic [PhaseW-1:0] PH_TAGS       = 4'd1;
  localparam logic [PhaseW-1:0] PH_PREFIX     = 4'd2;
  localparam logic [PhaseW-1:0] PH_NICK_FIRST = 4'd3;
  localparam logic [PhaseW-1:0] PH_NICK       = 4'd4;
  localparam logic [PhaseW-1:0] PH_USER_FIRST = 4'd5;
  localparam logic [PhaseW-1:0] PH_USER       = 4'd6;
  localparam logic [PhaseW-1:0] PH_HOST_FIRST = 4'd7;
  localparam logic [PhaseW-1:0] PH_HOST       = 4'd8;
  localparam logic [PhaseW-1:0] PH_CMD_START  = 4'd9;
  localparam logic [PhaseW-1:0] PH_CMD_ALPHA  = 4'd10;
  localparam logic [PhaseW-1:0] PH_CMD_DIGIT  = 4'd11;
  localparam logic [PhaseW-1:0] PH_AFTER_CMD  = 4'd12;
  localparam logic [PhaseW-1:0] PH_PARAMS     = 4'd13;
  localparam logic [PhaseW-1:0] PH_EXPECT_LF  = 4'd14;
  localparam logic [PhaseW-1:0] PH_HALT       = 4'd15;

  // Field classes.
  localparam logic [ClassW-1:0] CL_TAGS   = 3'd0;
  localparam logic [ClassW-1:0] CL_NICK   = 3'd1;
  localparam logic [ClassW-1:0] CL_USER   = 3'd2;
  localparam logic [ClassW-1:0] CL_HOST   = 3'd3;
  localparam logic [ClassW-1:0] CL_CMD    = 3'd4;
  localparam logic [ClassW-1:0] CL_PARAMS = 3'd5;
  localparam logic [ClassW-1:0] CL_DELIM  = 3'd6;
  localparam logic [ClassW-1:0] CL_ERR    = 3'd7;

  // Message error codes.
  localparam logic [ErrW-1:0] ERR_NONE   = 3'd0;
  localparam logic [ErrW-1:0] ERR_TAGS   = 3'd1;
  localparam logic [ErrW-1:0] ERR_NICK   = 3'd2;
  localparam logic [ErrW-1:0] ERR_USER   = 3'd3;
  localparam logic [ErrW-1:0] ERR_HOST   = 3'd4;
  localparam logic [ErrW-1:0] ERR_PREFIX = 3'd5;
  localparam logic [ErrW-1:0] ERR_CMD    = 3'd6;
  localparam logic [ErrW-1:0] ERR_CRLF   = 3'd7;

  // Special characters.
  localparam logic [ByteW-1:0] CH_NUL   = 8'h00;
  localparam logic [ByteW-1:0] CH_LF    = 8'h0A;
  localparam logic [ByteW-1:0] CH_CR    = 8'h0D;
  localparam logic [ByteW-1:0] CH_SPACE = 8'h20;
  localparam logic [ByteW-1:0] CH_BANG  = 8'h21;
  localparam logic [ByteW-1:0] CH_COLON = 8'h3A;
  localparam logic [ByteW-1:0] CH_AT    = 8'h40;

  // One labelled output word.
  typedef struct packed {
    logic [ByteW-1:0]  data_byte;
    logic [ClassW-1:0] field_class;
    logic              msg_end;
    logic [ErrW-1:0]   msg_error;
  } result_t;

endpackage

`default_nettype wire

// ===== hdl/ircfs_classify.sv =====
// Combinational byte classifier and phase update for the field splitter.
// Depends on ircfs_pkg for codes and the result word type.
`default_nettype none

module ircfs_classify (
  input  logic [ircfs_pkg::ByteW-1:0]  byte_i,
  input  logic [ircfs_pkg::PhaseW-1:0] phase_i,
  input  logic                         cr_seen_i,
  input  logic [ircfs_pkg::ErrW-1:0]   first_err_i,
  output logic [ircfs_pkg::PhaseW-1:0] phase_o,
  output logic                         cr_seen_o,
  output logic [ircfs_pkg::ErrW-1:0]   first_err_o,
  output ircfs_pkg::result_t           result_o
);
  import ircfs_pkg::*;

  // Error raised when the string ends while in a given phase.
  function automatic logic [ErrW-1:0] end_error(input logic [PhaseW-1:0] ph);
    logic [ErrW-1:0] e;
    unique case (ph)
      PH_TAGS:                        e = ERR_TAGS;
      PH_NICK_FIRST:                  e = ERR_NICK;
      PH_USER_FIRST:                  e = ERR_USER;
      PH_HOST_FIRST:                  e = ERR_HOST;
      PH_NICK, PH_USER, PH_HOST:      e = ERR_PREFIX;
      PH_START, PH_PREFIX,
      PH_CMD_START:                   e = ERR_CMD;
      default:                        e = ERR_CRLF;
    endcase
    return e;
  endfunction

  logic is_letter, is_num, closing;
  logic [PhaseW-1:0] eff_ph, cls_ph;
  logic [ErrW-1:0]   cls_err;
  logic [ClassW-1:0] cls;

  assign is_letter = (byte_i >= 8'h41 && byte_i <= 8'h5A) ||
                     (byte_i >= 8'h61 && byte_i <= 8'h7A);
  assign is_num    = byte_i >= 8'h30 && byte_i <= 8'h39;
  assign closing   = (byte_i == CH_LF) && cr_seen_i;

  // Resolve phases that hand the byte on without consuming it.
  always_comb begin
    eff_ph = phase_i;
    if (eff_ph == PH_START && byte_i != CH_AT) eff_ph = PH_PREFIX;
    if (eff_ph == PH_PREFIX && byte_i != CH_COLON) eff_ph = PH_CMD_START;
    if (eff_ph == PH_CMD_ALPHA && !is_letter) eff_ph = PH_AFTER_CMD;
    if (eff_ph == PH_CMD_DIGIT && !is_num) eff_ph = PH_AFTER_CMD;
  end

  // Classify the byte in the resolved phase.
  always_comb begin
    cls_ph  = eff_ph;
    cls_err = first_err_i;
    cls     = CL_ERR;
    if (phase_i == PH_HALT) begin
      cls_ph = PH_HALT;
    end else if (byte_i == CH_NUL) begin
      cls_ph  = PH_HALT;
      cls_err = end_error(phase_i);
    end else begin
      unique case (eff_ph)
        PH_START: begin
          cls_ph = PH_TAGS;
          cls    = CL_DELIM;
        end
        PH_TAGS: begin
          if (byte_i == CH_SPACE) begin
            cls_ph = PH_PREFIX;
            cls    = CL_DELIM;
          end else begin
            cls = CL_TAGS;
          end
        end
        PH_PREFIX: begin
          cls_ph = PH_NICK_FIRST;
          cls    = CL_DELIM;
        end
        PH_NICK_FIRST: begin
          if (byte_i == CH_SPACE || byte_i == CH_BANG) begin
            cls_ph  = PH_HALT;
            cls_err = ERR_NICK;
          end else begin
            cls_ph = PH_NICK;
            cls    = CL_NICK;
          end
        end
        PH_NICK: begin
          cls = CL_DELIM;
          if (byte_i == CH_SPACE) cls_ph = PH_CMD_START;
          else if (byte_i == CH_BANG) cls_ph = PH_USER_FIRST;
          else cls = CL_NICK;
        end
        PH_USER_FIRST: begin
          if (byte_i == CH_SPACE || byte_i == CH_AT) begin
            cls_ph  = PH_HALT;
            cls_err = ERR_USER;
          end else begin
            cls_ph = PH_USER;
            cls    = CL_USER;
          end
        end
        PH_USER: begin
          cls = CL_DELIM;
          if (byte_i == CH_SPACE) cls_ph = PH_CMD_START;
          else if (byte_i == CH_AT) cls_ph = PH_HOST_FIRST;
          else cls = CL_USER;
        end
        PH_HOST_FIRST: begin
          if (byte_i == CH_SPACE) begin
            cls_ph  = PH_HALT;
            cls_err = ERR_HOST;
          end else begin
            cls_ph = PH_HOST;
            cls    = CL_HOST;
          end
        end
        PH_HOST: begin
          if (byte_i == CH_SPACE) begin
            cls_ph = PH_CMD_START;
            cls    = CL_DELIM;
          end else begin
            cls = CL_HOST;
          end
        end
        PH_CMD_START: begin
          if (is_letter) begin
            cls_ph = PH_CMD_ALPHA;
            cls    = CL_CMD;
          end else if (is_num) begin
            cls_ph = PH_CMD_DIGIT;
            cls    = CL_CMD;
          end else begin
            cls_ph  = PH_HALT;
            cls_err = ERR_CMD;
          end
        end
        PH_CMD_ALPHA, PH_CMD_DIGIT: begin
          // Only a byte that continues the run gets here.
          cls = CL_CMD;
        end
        PH_AFTER_CMD: begin
          cls = CL_DELIM;
          if (byte_i == CH_SPACE) begin
            cls_ph = PH_PARAMS;
          end else if (byte_i == CH_CR) begin
            cls_ph = PH_EXPECT_LF;
          end else begin
            cls_ph  = PH_HALT;
            cls_err = ERR_CRLF;
            cls     = CL_ERR;
          end
        end
        PH_PARAMS: begin
          if (byte_i == CH_CR) begin
            cls_ph = PH_EXPECT_LF;
            cls    = CL_DELIM;
          end else begin
            cls = CL_PARAMS;
          end
        end
        PH_EXPECT_LF: begin
          cls_ph = PH_HALT;
          if (byte_i == CH_LF) begin
            cls = CL_DELIM;
          end else begin
            cls_err = ERR_CRLF;
          end
        end
        default: begin
          cls_ph = PH_HALT;
        end
      endcase
    end
  end

  // A closing LF reports the message error and restarts the parse.
  always_comb begin
    result_o.data_byte   = byte_i;
    result_o.field_class = cls;
    result_o.msg_end     = closing;
    result_o.msg_error   = ERR_NONE;
    if (closing) begin
      result_o.msg_error = (cls_ph != PH_HALT) ? end_error(cls_ph) : cls_err;
      phase_o            = PH_START;
      first_err_o        = ERR_NONE;
      cr_seen_o          = 1'b0;
    end else begin
      phase_o     = cls_ph;
      first_err_o = cls_err;
      cr_seen_o   = (byte_i == CH_CR);
    end
  end

endmodule

`default_nettype wire

// ===== hdl/ircfs_out_stage.sv =====
// Result register of the field splitter with valid and ready toward the sink.
// Depends on ircfs_pkg for the result word type.
`default_nettype none

module ircfs_out_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  ircfs_pkg::result_t result_i,
  output logic               valid_o,
  input  logic               ready_i,
  output ircfs_pkg::result_t result_o
);
  import ircfs_pkg::*;

  logic    valid_q;
  result_t result_q;

  // The register takes a word when empty or when its word leaves.
  assign ready_o  = !valid_q || ready_i;
  assign valid_o  = valid_q;
  assign result_o = result_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      result_q <= result_i;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/irc_message_field_splitter.sv =====
// Chat message field splitter: labels each byte of a message line by field.
// Each accepted byte passes through the input register and then the result register;
// throughput is one byte per cycle while the output is not stalled, set by the combinational
// phase update between the input register and the result register.
// Stalls at the output back up word by word.
// Reset clears the phase to message start, the CR flag, the error and all valids.
`default_nettype none

module irc_message_field_splitter (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [ircfs_pkg::ByteW-1:0]  byte_in_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [ircfs_pkg::ByteW-1:0]  data_byte_o,
  output logic [ircfs_pkg::ClassW-1:0] field_class_o,
  output logic                        msg_end_o,
  output logic [ircfs_pkg::ErrW-1:0]   msg_error_o
);
  import ircfs_pkg::*;

  logic              in_valid_q;
  logic [ByteW-1:0]  byte_q;
  logic [PhaseW-1:0] phase_q, phase_d;
  logic              cr_seen_q, cr_seen_d;
  logic [ErrW-1:0]   err_q, err_d;
  logic              stage_ready, advance;
  result_t           res_d, res_out;

  assign advance    = in_valid_q && stage_ready;
  assign in_ready_o = !in_valid_q || stage_ready;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      byte_q <= byte_in_i;
    end
  end

  // Parse state moves on as each word passes into the result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_START;
      cr_seen_q <= 1'b0;
      err_q     <= ERR_NONE;
    end else if (advance) begin
      phase_q   <= phase_d;
      cr_seen_q <= cr_seen_d;
      err_q     <= err_d;
    end
  end

  ircfs_classify u_classify (
    .byte_i      (byte_q),
    .phase_i     (phase_q),
    .cr_seen_i   (cr_seen_q),
    .first_err_i (err_q),
    .phase_o     (phase_d),
    .cr_seen_o   (cr_seen_d),
    .first_err_o (err_d),
    .result_o    (res_d)
  );

  ircfs_out_stage u_out_stage (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (in_valid_q),
    .ready_o  (stage_ready),
    .result_i (res_d),
    .valid_o  (out_valid_o),
    .ready_i  (out_ready_i),
    .result_o (res_out)
  );

  assign data_byte_o   = res_out.data_byte;
  assign field_class_o = res_out.field_class;
  assign msg_end_o     = res_out.msg_end;
  assign msg_error_o   = res_out.msg_error;

  // An error code is only reported with the end of a message.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !msg_end_o |-> msg_error_o == ERR_NONE)
    else $error("error code outside end of message");

  // A closing word restarts the parse with a clean error.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && res_d.msg_end |=> phase_q == PH_START && err_q == ERR_NONE && !cr_seen_q)
    else $error("parse state not restarted after message end");

  // An error-class word that does not close the message leaves the parser halted.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && res_d.field_class == CL_ERR && !res_d.msg_end |=> phase_q == PH_HALT)
    else $error("parser not halted after error");

  // Input is held back only while a word sits in the input register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> in_valid_q && out_valid_o && !out_ready_i)
    else $error("input stalled without cause");

endmodule

`default_nettype wire
